// File: src/matrix3_inverse_core_macros.svh
// Assertion helpers shared by the matrix inverse core.
`ifndef MATRIX3_INVERSE_CORE_MACROS_SVH
`define MATRIX3_INVERSE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define M3I_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define M3I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/m3i_pkg.sv
package m3i_pkg;

   // Width and reset value of the singular threshold register.
   localparam int EPS_WIDTH = 31;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 31'd7;

   // Per-beat control that travels alongside the divider lanes.
   typedef struct packed {
      logic singular;
      logic det_neg;
   } lane_ctl_type;

endpackage

// File: src/m3i_req_if.sv
interface m3i_req_if #(parameter int ELEM_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] elem_r0c0;
   logic signed [ELEM_WIDTH-1:0] elem_r1c0;
   logic signed [ELEM_WIDTH-1:0] elem_r2c0;
   logic signed [ELEM_WIDTH-1:0] elem_r0c1;
   logic signed [ELEM_WIDTH-1:0] elem_r1c1;
   logic signed [ELEM_WIDTH-1:0] elem_r2c1;
   logic signed [ELEM_WIDTH-1:0] elem_r0c2;
   logic signed [ELEM_WIDTH-1:0] elem_r1c2;
   logic signed [ELEM_WIDTH-1:0] elem_r2c2;

   modport source (
      output valid, elem_r0c0, elem_r1c0, elem_r2c0, elem_r0c1, elem_r1c1,
             elem_r2c1, elem_r0c2, elem_r1c2, elem_r2c2,
      input  ready
   );

   modport sink (
      input  valid, elem_r0c0, elem_r1c0, elem_r2c0, elem_r0c1, elem_r1c1,
             elem_r2c1, elem_r0c2, elem_r1c2, elem_r2c2,
      output ready
   );
endinterface

// File: src/m3i_rsp_if.sv
interface m3i_rsp_if #(parameter int ELEM_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] inv_r0c0;
   logic signed [ELEM_WIDTH-1:0] inv_r1c0;
   logic signed [ELEM_WIDTH-1:0] inv_r2c0;
   logic signed [ELEM_WIDTH-1:0] inv_r0c1;
   logic signed [ELEM_WIDTH-1:0] inv_r1c1;
   logic signed [ELEM_WIDTH-1:0] inv_r2c1;
   logic signed [ELEM_WIDTH-1:0] inv_r0c2;
   logic signed [ELEM_WIDTH-1:0] inv_r1c2;
   logic signed [ELEM_WIDTH-1:0] inv_r2c2;
   logic signed [ELEM_WIDTH-1:0] determinant;
   logic                         singular;

   modport source (
      output valid, inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, inv_r1c1, inv_r2c1,
             inv_r0c2, inv_r1c2, inv_r2c2, determinant, singular,
      input  ready
   );

   modport sink (
      input  valid, inv_r0c0, inv_r1c0, inv_r2c0, inv_r0c1, inv_r1c1, inv_r2c1,
             inv_r0c2, inv_r1c2, inv_r2c2, determinant, singular,
      output ready
   );
endinterface

// File: src/matrix3_inverse_core.sv
// 3x3 matrix inverse by the adjugate method, signed fixed point (Q16.16 default).
// Input beats arrive on req_bus: nine elements in column-major order. Result
// beats leave on rsp_bus: the nine inverse elements in the same order, the
// determinant and a singular flag. Every input beat yields one result beat.
// csr_wr_en / csr_wr_data write the singular threshold (an unsigned Q15.16 magnitude);
// a matrix whose determinant magnitude is below it, or is zero, is reported
// singular with all inverse elements zero. Write it only while idle.
// Throughput is one beat per cycle while the receiver keeps rsp ready high.
// The pipeline holds four cofactor and determinant stages, two stages of
// magnitude and threshold logic, then nine divider lanes working side by
// side, each a pipelined restoring divider with one quotient bit per stage,
// and a final saturation register.
// The whole pipeline advances together; when the receiver holds rsp ready low
// while a result is waiting, req ready drops and every stage holds its data.
// Reset is synchronous and active high: it empties the pipeline and loads the
// threshold with its reset value of 7.
module matrix3_inverse_core #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [m3i_pkg::EPS_WIDTH-1:0]   csr_wr_data,
   m3i_req_if.sink                         req_bus,
   m3i_rsp_if.source                       rsp_bus
);
   import m3i_pkg::*;

   `include "matrix3_inverse_core_macros.svh"

   localparam int W        = ELEM_WIDTH;
   localparam int CW       = 2 * W + 1;
   localparam int DTW      = 3 * W + 2;
   localparam int DW       = 3 * W + 1;
   localparam int EPSW     = EPS_WIDTH + 2 * FRAC_BITS;
   localparam int CMPW     = (DW > EPSW) ? DW : EPSW;
   localparam int LANE_LAT = W + 2;
   localparam int LAT      = W + 8;
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   logic                  en;
   logic [LAT-1:0]        vld_ff;
   logic [EPS_WIDTH-1:0]  eps_ff;

   logic signed [W-1:0]   elem [9];
   logic signed [CW-1:0]  cof_d [9];
   logic signed [DTW-1:0] det_d;

   // Stage E: determinant magnitude and sign.
   logic [DW-1:0]         mag_e_ff;
   logic                  neg_e_ff;
   logic signed [CW-1:0]  cof_e_ff [9];
   logic [DW-1:0]         mag_e_in;

   // Stage F: threshold compare and scaled determinant.
   logic [DW-1:0]         mag_f_ff;
   logic signed [CW-1:0]  cof_f_ff [9];
   lane_ctl_type          ctl_f_ff;
   logic [W-1:0]          det_f_ff;
   logic                  sing_f_in;
   logic [DW-1:0]         det_sh;
   logic                  det_ge;
   logic                  det_eq;
   logic [W-1:0]          det_f_in;

   // Delay line that keeps the determinant and flag beside the lanes.
   logic [W-1:0]          det_dl_ff  [LANE_LAT];
   logic                  sing_dl_ff [LANE_LAT];

   logic signed [W-1:0]   inv [9];

   // Every stage advances together unless a finished beat is being held.
   assign en            = !vld_ff[LAT-1] || rsp_bus.ready;
   assign req_bus.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         eps_ff <= EPS_RESET;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
         end
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
      end
   end

   assign elem[0] = req_bus.elem_r0c0;
   assign elem[1] = req_bus.elem_r1c0;
   assign elem[2] = req_bus.elem_r2c0;
   assign elem[3] = req_bus.elem_r0c1;
   assign elem[4] = req_bus.elem_r1c1;
   assign elem[5] = req_bus.elem_r2c1;
   assign elem[6] = req_bus.elem_r0c2;
   assign elem[7] = req_bus.elem_r1c2;
   assign elem[8] = req_bus.elem_r2c2;

   m3i_cofactor_det #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_cofactor_det (
      .clock (clock),
      .en    (en),
      .elem  (elem),
      .cof   (cof_d),
      .det   (det_d)
   );

   always_comb begin
      mag_e_in = det_d[DTW-1] ? DW'(-det_d) : DW'(det_d);
   end

   // The determinant output keeps only the element fraction: the magnitude
   // is shifted down, then saturated with the sign restored.
   always_comb begin
      sing_f_in = (mag_e_ff == '0) ||
                  (CMPW'(mag_e_ff) < (CMPW'(eps_ff) << (2 * FRAC_BITS)));
      det_sh    = mag_e_ff >> (2 * FRAC_BITS);
      det_ge    = |(det_sh >> (W - 1));
      det_eq    = det_sh == (DW'(1) << (W - 1));
      if (!neg_e_ff) begin
         det_f_in = det_ge ? SAT_MAX : det_sh[W-1:0];
      end else if (det_ge && !det_eq) begin
         det_f_in = SAT_MIN;
      end else begin
         det_f_in = W'(-det_sh[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_e_ff          <= mag_e_in;
         neg_e_ff          <= det_d[DTW-1];
         mag_f_ff          <= mag_e_ff;
         ctl_f_ff.singular <= sing_f_in;
         ctl_f_ff.det_neg  <= neg_e_ff;
         det_f_ff          <= det_f_in;
         for (int k = 0; k < 9; k++) begin
            cof_e_ff[k] <= cof_d[k];
            cof_f_ff[k] <= cof_e_ff[k];
         end
         det_dl_ff[0]  <= det_f_ff;
         sing_dl_ff[0] <= ctl_f_ff.singular;
         for (int i = 1; i < LANE_LAT; i++) begin
            det_dl_ff[i]  <= det_dl_ff[i-1];
            sing_dl_ff[i] <= sing_dl_ff[i-1];
         end
      end
   end

   // Nine divider lanes, one per inverse element.
   for (genvar k = 0; k < 9; k++) begin : g_lane
      m3i_div_lane #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .en      (en),
         .cof     (cof_f_ff[k]),
         .det_mag (mag_f_ff),
         .ctl     (ctl_f_ff),
         .inv     (inv[k])
      );
   end

   // The lane registers and the delay line's last tap form the result beat.
   assign rsp_bus.valid       = vld_ff[LAT-1];
   assign rsp_bus.inv_r0c0    = inv[0];
   assign rsp_bus.inv_r1c0    = inv[1];
   assign rsp_bus.inv_r2c0    = inv[2];
   assign rsp_bus.inv_r0c1    = inv[3];
   assign rsp_bus.inv_r1c1    = inv[4];
   assign rsp_bus.inv_r2c1    = inv[5];
   assign rsp_bus.inv_r0c2    = inv[6];
   assign rsp_bus.inv_r1c2    = inv[7];
   assign rsp_bus.inv_r2c2    = inv[8];
   assign rsp_bus.determinant = $signed(det_dl_ff[LANE_LAT-1]);
   assign rsp_bus.singular    = sing_dl_ff[LANE_LAT-1];

   `M3I_ASSERT_SAME(a_singular_zero, clock, reset, rsp_bus.valid && rsp_bus.singular, (rsp_bus.inv_r0c0 == '0) && (rsp_bus.inv_r1c1 == '0) && (rsp_bus.inv_r2c2 == '0) && (rsp_bus.inv_r2c0 == '0) && (rsp_bus.inv_r0c2 == '0), "singular result carries a nonzero inverse element")
   `M3I_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready, "input accepted while a result beat is held")
   `M3I_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_bus.valid, "result beat offered right after reset")
endmodule

// File: src/m3i_cofactor_det.sv
module m3i_cofactor_det #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [ELEM_WIDTH-1:0]   elem [9],
   output logic signed [2*ELEM_WIDTH:0]   cof [9],
   output logic signed [3*ELEM_WIDTH+1:0] det
);
   import m3i_pkg::*;

   localparam int W   = ELEM_WIDTH;
   localparam int PW  = 2 * W;
   localparam int CW  = 2 * W + 1;
   localparam int LPW = 2 * W + 1;
   localparam int DTW = 3 * W + 2;

   // Cofactor k is elem[IA]*elem[IB] - elem[IC]*elem[ID], column-major indexes.
   localparam int IA [9] = '{4, 7, 1, 5, 0, 2, 3, 6, 0};
   localparam int IB [9] = '{8, 2, 5, 6, 8, 3, 7, 1, 4};
   localparam int IC [9] = '{5, 8, 2, 3, 2, 0, 4, 7, 1};
   localparam int ID [9] = '{7, 1, 4, 8, 6, 5, 6, 0, 3};
   // The determinant expands along column zero.
   localparam int DC [3] = '{0, 3, 6};

   logic signed [PW-1:0]  pa_ff [9];
   logic signed [PW-1:0]  pb_ff [9];
   logic signed [W-1:0]   am_ff [3];
   logic signed [CW-1:0]  cof_ff [9];
   logic signed [W-1:0]   ab_ff [3];
   logic signed [LPW-1:0] plo_ff [3];
   logic signed [LPW-1:0] phi_ff [3];
   logic signed [CW-1:0]  cofc_ff [9];
   logic signed [CW-1:0]  cofd_ff [9];
   logic signed [DTW-1:0] det_ff;
   logic signed [DTW-1:0] det_in;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            pa_ff[k]   <= elem[IA[k]] * elem[IB[k]];
            pb_ff[k]   <= elem[IC[k]] * elem[ID[k]];
            cof_ff[k]  <= CW'(pa_ff[k]) - CW'(pb_ff[k]);
            cofc_ff[k] <= cof_ff[k];
            cofd_ff[k] <= cofc_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            am_ff[j]  <= elem[j];
            ab_ff[j]  <= am_ff[j];
            // Each wide product is split into two narrow partial products.
            plo_ff[j] <= ab_ff[j] * $signed({1'b0, cof_ff[DC[j]][W-1:0]});
            phi_ff[j] <= ab_ff[j] * $signed(cof_ff[DC[j]][CW-1:W]);
         end
         det_ff <= det_in;
      end
   end

   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (DTW'(phi_ff[j]) <<< W) + DTW'(plo_ff[j]);
      end
   end

   assign cof = cofd_ff;
   assign det = det_ff;
endmodule

// File: src/m3i_div_lane.sv
module m3i_div_lane #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [2*ELEM_WIDTH:0]    cof,
   input  logic        [3*ELEM_WIDTH:0]    det_mag,
   input  m3i_pkg::lane_ctl_type           ctl,
   output logic signed [ELEM_WIDTH-1:0]    inv
);
   import m3i_pkg::*;

   localparam int W   = ELEM_WIDTH;
   localparam int CW  = 2 * W + 1;
   localparam int DW  = 3 * W + 1;
   localparam int NW  = CW + 2 * FRAC_BITS;
   localparam int RW  = (NW > DW + W) ? NW : DW + W;
   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   logic [RW-1:0] rem_ff  [W+1];
   logic [DW-1:0] dv_ff   [W+1];
   logic [W-1:0]  q_ff    [W+1];
   logic          ovf_ff  [W+1];
   logic          neg_ff  [W+1];
   logic          sing_ff [W+1];
   logic [W-1:0]  inv_ff;

   logic [CW-1:0] cof_mag;
   logic [RW-1:0] num;
   logic [W-1:0]  q_last;
   logic [W-1:0]  inv_in;

   always_comb begin
      cof_mag = cof[CW-1] ? CW'(-cof) : CW'(cof);
      num     = RW'(cof_mag) << (2 * FRAC_BITS);
   end

   // Setup: numerator magnitude, quotient sign and the too-large check.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         dv_ff[0]   <= det_mag;
         q_ff[0]    <= '0;
         ovf_ff[0]  <= num >= (RW'(det_mag) << W);
         neg_ff[0]  <= cof[CW-1] ^ ctl.det_neg;
         sing_ff[0] <= ctl.singular;
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar k = 1; k <= W; k++) begin : g_step
      logic [RW-1:0] trial;
      logic          take;
      logic [W-1:0]  q_nxt;

      always_comb begin
         trial = RW'(dv_ff[k-1]) << (W - k);
         take  = rem_ff[k-1] >= trial;
         q_nxt = q_ff[k-1];
         q_nxt[W-k] = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
            dv_ff[k]   <= dv_ff[k-1];
            q_ff[k]    <= q_nxt;
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
         end
      end
   end

   always_comb begin
      q_last = q_ff[W];
      if (sing_ff[W]) begin
         inv_in = '0;
      end else if (!neg_ff[W]) begin
         inv_in = (ovf_ff[W] || q_last[W-1]) ? SAT_MAX : q_last;
      end else if (ovf_ff[W] || (q_last[W-1] && (|q_last[W-2:0]))) begin
         inv_in = SAT_MIN;
      end else begin
         inv_in = W'(-q_last);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff <= inv_in;
      end
   end

   assign inv = $signed(inv_ff);
endmodule
